// File: rtl/core/assert_macros.svh
// ----------------------------------------------------------------------------
// assert_macros.svh
// shared concurrent assertion macros, sampled on a clock, disabled while reset is low
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// antecedent implies consequent in the same cycle
`define STDE_ASSERT_IMPL(name, clk, rst_n, ante, cons, msg) \
    name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// expression must never hold
`define STDE_ASSERT_NEVER(name, clk, rst_n, expr, msg) \
    name: assert property (@(posedge clk) disable iff (!rst_n) !(expr)) \
        else $error(msg);

`endif

// File: rtl/core/stde_pkg.sv
// ----------------------------------------------------------------------------
// stde_pkg
// constants, tables and types shared by the strobe tuner display engine
// ----------------------------------------------------------------------------
package stde_pkg;

    // display and tuning geometry
    localparam int STRINGS     = 6;
    localparam int COLUMNS     = 128;
    localparam int ROWS        = 64;
    localparam int SAMPLE_RATE = 96000;
    localparam int VSPACE      = ROWS / STRINGS;

    // field widths
    localparam int SAMPLE_W   = 24;
    localparam int PHASE_W    = 32;
    localparam int SMOOTH_W   = 16;
    localparam int CFG_DATA_W = 32;
    localparam int CFG_IDX_W  = 2;
    localparam int IDX_OUT_W  = 3;
    localparam int COL_OUT_W  = 7;
    localparam int ROW_OUT_W  = 6;

    // derived widths
    localparam int COL_W       = $clog2(COLUMNS);
    localparam int ROW_W       = $clog2(ROWS);
    localparam int J_W         = (STRINGS > 1) ? $clog2(STRINGS) : 1;
    localparam int STORE_DEPTH = STRINGS * COLUMNS;
    localparam int ADDR_W      = $clog2(STORE_DEPTH);
    localparam int PROD_W      = SMOOTH_W + SAMPLE_W + 2;
    localparam int T_W         = 48;
    localparam int Y_SHIFT     = 23;
    localparam int Y_W         = T_W - Y_SHIFT;
    localparam int DIV_CNT_W   = $clog2(PHASE_W);
    localparam int DIV_REM_W   = J_W + 2;

    // draw thresholds and pixel gain
    localparam int EPS_Q     = 8388;
    localparam int OVER_GAIN = 12;
    localparam logic signed [SAMPLE_W-1:0] EPS_V     = SAMPLE_W'(EPS_Q);
    localparam logic signed [SAMPLE_W-1:0] NEG_EPS_V = -SAMPLE_W'(EPS_Q);
    localparam logic signed [T_W-1:0]      PIX_GAIN  = T_W'(OVER_GAIN * VSPACE);
    localparam logic [PROD_W-1:0]          BLEND_RND = PROD_W'(1 << (SMOOTH_W - 1));

    // built-in string notes, q16.16 hz, and their phase steps per sample
    localparam int NOTES  = 6;
    localparam int NOTE_W = $clog2(NOTES);
    localparam logic [63:0] NOTE_HZ_Q16 [NOTES] = '{
        64'd1350154, 64'd1802240, 64'd2405702,
        64'd3211227, 64'd4045892, 64'd5400618
    };
    localparam logic [PHASE_W-1:0] NOTE_INC [NOTES] = '{
        PHASE_W'(((NOTE_HZ_Q16[0] << 16) + SAMPLE_RATE / 2) / SAMPLE_RATE),
        PHASE_W'(((NOTE_HZ_Q16[1] << 16) + SAMPLE_RATE / 2) / SAMPLE_RATE),
        PHASE_W'(((NOTE_HZ_Q16[2] << 16) + SAMPLE_RATE / 2) / SAMPLE_RATE),
        PHASE_W'(((NOTE_HZ_Q16[3] << 16) + SAMPLE_RATE / 2) / SAMPLE_RATE),
        PHASE_W'(((NOTE_HZ_Q16[4] << 16) + SAMPLE_RATE / 2) / SAMPLE_RATE),
        PHASE_W'(((NOTE_HZ_Q16[5] << 16) + SAMPLE_RATE / 2) / SAMPLE_RATE)
    };

    // command kinds
    localparam logic KIND_LINE  = 1'b0;
    localparam logic KIND_PIXEL = 1'b1;

    // configuration register map
    typedef enum logic [CFG_IDX_W-1:0] {
        REG_REF_INC  = 2'd0,
        REG_SMOOTH   = 2'd1,
        REG_BARS     = 2'd2,
        REG_REF_MODE = 2'd3
    } t_cfg_reg;

    // sequencer states
    typedef enum logic [3:0] {
        S_CLEAR,
        S_IDLE,
        S_DIV,
        S_DIV_STORE,
        S_RD,
        S_MUL,
        S_BLEND,
        S_PIX,
        S_LINE,
        S_PIXOUT,
        S_ADV,
        S_FLUSH
    } t_state;

    // one draw command
    typedef struct packed {
        logic                 kind;
        logic [IDX_OUT_W-1:0] string_index;
        logic [COL_OUT_W-1:0] column;
        logic [ROW_OUT_W-1:0] row_top;
        logic [ROW_OUT_W-1:0] row_bottom;
        logic                 lit;
    } t_draw_cmd;

    // controller to datapath commands
    typedef struct packed {
        logic cfg_ready;
        logic sample_stall;
        logic clr_step;
        logic take_sample;
        logic rd;
        logic mul;
        logic blend;
        logic pix;
        logic push_line;
        logic push_pix;
        logic adv;
        logic flush;
        logic div_start;
        logic div_step;
        logic div_store;
    } t_ctl;

    // datapath to controller status
    typedef struct packed {
        logic clr_done;
        logic div_req;
        logic div_last_bit;
        logic j_last;
        logic line_need;
        logic pix_need;
        logic pend_vld;
        logic out_free;
    } t_sts;

endpackage

// File: rtl/core/stde_ctrl.sv
// ----------------------------------------------------------------------------
// stde_ctrl
// sequencer: store clearing, reference step division and per-string steps
// ----------------------------------------------------------------------------
module stde_ctrl (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_sample_valid,
    input  logic            i_cfg_valid,
    input  stde_pkg::t_sts  i_sts,
    output stde_pkg::t_ctl  o_ctl
);

    stde_pkg::t_state r_state;
    stde_pkg::t_state n_state;
    logic             push_ok;

    // state register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= stde_pkg::S_CLEAR;
        end else begin
            r_state <= n_state;
        end
    end

    // a new command may enter the holding slot
    assign push_ok = !i_sts.pend_vld || i_sts.out_free;

    // next state and commands
    always_comb begin
        n_state            = r_state;
        o_ctl              = '0;
        o_ctl.sample_stall = 1'b1;
        case (r_state)
            stde_pkg::S_CLEAR: begin
                o_ctl.cfg_ready = 1'b1;
                o_ctl.clr_step  = 1'b1;
                if (i_sts.clr_done) begin
                    n_state = stde_pkg::S_IDLE;
                end
            end
            stde_pkg::S_IDLE: begin
                o_ctl.cfg_ready    = !i_sts.div_req;
                o_ctl.sample_stall = i_sts.div_req || i_cfg_valid;
                if (i_sts.div_req) begin
                    o_ctl.div_start = 1'b1;
                    n_state         = stde_pkg::S_DIV;
                end else if (i_sample_valid && !i_cfg_valid) begin
                    o_ctl.take_sample = 1'b1;
                    n_state           = stde_pkg::S_RD;
                end
            end
            stde_pkg::S_DIV: begin
                o_ctl.div_step = 1'b1;
                if (i_sts.div_last_bit) begin
                    n_state = stde_pkg::S_DIV_STORE;
                end
            end
            stde_pkg::S_DIV_STORE: begin
                o_ctl.div_store = 1'b1;
                n_state = i_sts.j_last ? stde_pkg::S_IDLE : stde_pkg::S_DIV;
            end
            stde_pkg::S_RD: begin
                o_ctl.rd = 1'b1;
                n_state  = stde_pkg::S_MUL;
            end
            stde_pkg::S_MUL: begin
                o_ctl.mul = 1'b1;
                n_state   = stde_pkg::S_BLEND;
            end
            stde_pkg::S_BLEND: begin
                o_ctl.blend = 1'b1;
                n_state     = stde_pkg::S_PIX;
            end
            stde_pkg::S_PIX: begin
                o_ctl.pix = 1'b1;
                n_state   = stde_pkg::S_LINE;
            end
            stde_pkg::S_LINE: begin
                if (!i_sts.line_need) begin
                    n_state = stde_pkg::S_PIXOUT;
                end else if (push_ok) begin
                    o_ctl.push_line = 1'b1;
                    n_state         = stde_pkg::S_PIXOUT;
                end
            end
            stde_pkg::S_PIXOUT: begin
                if (!i_sts.pix_need) begin
                    n_state = stde_pkg::S_ADV;
                end else if (push_ok) begin
                    o_ctl.push_pix = 1'b1;
                    n_state        = stde_pkg::S_ADV;
                end
            end
            stde_pkg::S_ADV: begin
                o_ctl.adv = 1'b1;
                n_state = i_sts.j_last ? stde_pkg::S_FLUSH : stde_pkg::S_RD;
            end
            stde_pkg::S_FLUSH: begin
                if (!i_sts.pend_vld) begin
                    n_state = stde_pkg::S_IDLE;
                end else if (i_sts.out_free) begin
                    o_ctl.flush = 1'b1;
                    n_state     = stde_pkg::S_IDLE;
                end
            end
            default: begin
                n_state = stde_pkg::S_IDLE;
            end
        endcase
    end

endmodule

// File: rtl/core/stde_dpath.sv
// ----------------------------------------------------------------------------
// stde_dpath
// phase accumulators, strobe store, blend multiplier, pixel row, step divider
// and the command holding slot and output register
// ----------------------------------------------------------------------------
module stde_dpath (
    input  logic                                   i_clk,
    input  logic                                   i_rst_n,
    input  stde_pkg::t_ctl                         i_ctl,
    output stde_pkg::t_sts                         o_sts,
    input  logic                                   i_cfg_valid,
    input  logic [stde_pkg::CFG_IDX_W-1:0]         i_cfg_index,
    input  logic [stde_pkg::CFG_DATA_W-1:0]        i_cfg_data,
    input  logic signed [stde_pkg::SAMPLE_W-1:0]   i_sample,
    input  logic                                   i_cmd_stall,
    output stde_pkg::t_draw_cmd                    o_cmd,
    output logic                                   o_cmd_last,
    output logic                                   o_cmd_valid
);

    // configuration registers
    logic [stde_pkg::PHASE_W-1:0]  r_ref_inc;
    logic [stde_pkg::SMOOTH_W-1:0] r_smooth;
    logic                          r_bars;
    logic                          r_ref_mode;
    logic                          r_div_req;

    // per-string state
    logic [stde_pkg::PHASE_W-1:0] r_phase    [stde_pkg::STRINGS];
    logic [stde_pkg::COL_W-1:0]   r_last_col [stde_pkg::STRINGS];
    logic                         r_last_vld [stde_pkg::STRINGS];
    logic [stde_pkg::PHASE_W-1:0] r_ref_step [stde_pkg::STRINGS];

    // strobe store
    logic signed [stde_pkg::SAMPLE_W-1:0] mem [stde_pkg::STORE_DEPTH];
    logic [stde_pkg::ADDR_W-1:0]          r_clr_addr;
    logic [stde_pkg::ADDR_W-1:0]          r_addr;
    logic signed [stde_pkg::SAMPLE_W-1:0] r_rdata;

    // per-sample working registers
    logic signed [stde_pkg::SAMPLE_W-1:0] r_s;
    logic [stde_pkg::J_W-1:0]             r_j;
    logic [stde_pkg::NOTE_W-1:0]          r_note;
    logic [stde_pkg::COL_W-1:0]           r_col;
    logic signed [stde_pkg::PROD_W-1:0]   r_prod;
    logic signed [stde_pkg::SAMPLE_W-1:0] r_v;
    logic [stde_pkg::ROW_W-1:0]           r_y;

    // step divider
    logic [stde_pkg::PHASE_W-1:0]   r_div_num;
    logic [stde_pkg::PHASE_W-1:0]   r_div_q;
    logic [stde_pkg::DIV_REM_W-1:0] r_div_rem;
    logic [stde_pkg::DIV_CNT_W-1:0] r_div_cnt;

    // holding slot and output register
    stde_pkg::t_draw_cmd r_pend;
    logic                r_pend_vld;
    stde_pkg::t_draw_cmd r_out;
    logic                r_out_last;
    logic                r_out_vld;

    // combinational helpers
    logic                                 cfg_wr;
    logic [stde_pkg::COL_W-1:0]           col_cur;
    logic [stde_pkg::ADDR_W-1:0]          addr_cur;
    logic signed [stde_pkg::SAMPLE_W:0]   diff;
    logic signed [stde_pkg::PROD_W-1:0]   n_prod;
    logic signed [stde_pkg::PROD_W-1:0]   blend_sum;
    logic signed [stde_pkg::SAMPLE_W-1:0] n_v;
    logic signed [stde_pkg::T_W-1:0]      pix_base;
    logic signed [stde_pkg::T_W-1:0]      pix_t;
    logic signed [stde_pkg::Y_W-1:0]      y_raw;
    logic signed [stde_pkg::Y_W-1:0]      y_lo;
    logic signed [stde_pkg::Y_W-1:0]      y_hi;
    logic [stde_pkg::ROW_W-1:0]           n_y;
    logic [stde_pkg::DIV_REM_W-1:0]       div_dvsr;
    logic [stde_pkg::DIV_REM_W-1:0]       div_sh;
    logic                                 div_bit;
    logic [stde_pkg::PHASE_W-1:0]         step_inc;
    logic                                 line_lit;
    stde_pkg::t_draw_cmd                  new_cmd;
    logic                                 push;
    stde_pkg::t_draw_cmd                  n_out;
    logic                                 n_out_last;
    logic                                 n_out_vld;

    assign cfg_wr = i_cfg_valid && i_ctl.cfg_ready;

    // configuration writes and divide request
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ref_inc  <= '0;
            r_smooth   <= '0;
            r_bars     <= 1'b1;
            r_ref_mode <= 1'b0;
            r_div_req  <= 1'b0;
        end else begin
            if (cfg_wr) begin
                case (stde_pkg::t_cfg_reg'(i_cfg_index))
                    stde_pkg::REG_REF_INC: begin
                        r_ref_inc <= i_cfg_data;
                        r_div_req <= 1'b1;
                    end
                    stde_pkg::REG_SMOOTH:   r_smooth   <= i_cfg_data[stde_pkg::SMOOTH_W-1:0];
                    stde_pkg::REG_BARS:     r_bars     <= i_cfg_data[0];
                    stde_pkg::REG_REF_MODE: r_ref_mode <= i_cfg_data[0];
                    default: begin
                    end
                endcase
            end else if (i_ctl.div_start) begin
                r_div_req <= 1'b0;
            end
        end
    end

    // column of the current string and its store address
    assign col_cur  = stde_pkg::COL_W'((64'(r_phase[r_j]) * 64'(stde_pkg::COLUMNS))
                      >> stde_pkg::PHASE_W);
    assign addr_cur = stde_pkg::ADDR_W'(32'(r_j) * 32'(stde_pkg::COLUMNS) + 32'(col_cur));

    // blend: s*2^16 + r*(stored - s), rounded half up; s itself in reference mode
    assign diff      = {r_rdata[stde_pkg::SAMPLE_W-1], r_rdata} - {r_s[stde_pkg::SAMPLE_W-1], r_s};
    assign n_prod    = $signed({1'b0, r_smooth}) * diff;
    assign blend_sum = ($signed(stde_pkg::PROD_W'(r_s)) <<< stde_pkg::SMOOTH_W) + r_prod
                       + $signed(stde_pkg::BLEND_RND);
    assign n_v       = r_ref_mode ? r_s
                       : blend_sum[stde_pkg::SMOOTH_W +: stde_pkg::SAMPLE_W];

    // pixel row inside the string band
    assign pix_base = $signed(stde_pkg::T_W'((64'(r_j) * 2 + 1) * stde_pkg::VSPACE)
                      << (stde_pkg::Y_SHIFT - 1));
    assign pix_t    = pix_base + $signed(stde_pkg::T_W'(r_v)) * stde_pkg::PIX_GAIN;
    assign y_raw    = pix_t[stde_pkg::T_W-1:stde_pkg::Y_SHIFT];
    assign y_lo     = stde_pkg::Y_W'(32'(r_j) * 32'(stde_pkg::VSPACE));
    assign y_hi     = y_lo + stde_pkg::Y_W'(stde_pkg::VSPACE - 1);
    always_comb begin
        if (y_raw < y_lo) begin
            n_y = stde_pkg::ROW_W'(y_lo);
        end else if (y_raw > y_hi) begin
            n_y = stde_pkg::ROW_W'(y_hi);
        end else begin
            n_y = stde_pkg::ROW_W'(y_raw);
        end
    end

    // restoring divide of the reference step by string number, one bit a cycle
    assign div_dvsr = stde_pkg::DIV_REM_W'(r_j) + 1'b1;
    assign div_sh   = {r_div_rem[stde_pkg::DIV_REM_W-2:0], r_div_num[stde_pkg::PHASE_W-1]};
    assign div_bit  = (div_sh >= div_dvsr);

    // phase step of the current string
    assign step_inc = r_ref_mode ? r_ref_step[r_j] : stde_pkg::NOTE_INC[r_note];

    // store clearing, read and write
    always_ff @(posedge i_clk) begin
        if (i_ctl.clr_step) begin
            mem[r_clr_addr] <= '0;
        end else if (i_ctl.blend && !r_ref_mode) begin
            mem[r_addr] <= n_v;
        end
        if (i_ctl.rd) begin
            r_rdata <= mem[addr_cur];
        end
    end

    // clear pointer
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_clr_addr <= '0;
        end else if (i_ctl.clr_step) begin
            r_clr_addr <= r_clr_addr + 1'b1;
        end
    end

    // per-string state and string counter
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_j    <= '0;
            r_note <= '0;
            for (int k = 0; k < stde_pkg::STRINGS; k++) begin
                r_phase[k]    <= '0;
                r_last_vld[k] <= 1'b0;
                r_ref_step[k] <= '0;
            end
        end else begin
            if (i_ctl.take_sample || i_ctl.div_start) begin
                r_j    <= '0;
                r_note <= '0;
            end else if (i_ctl.adv) begin
                r_phase[r_j]    <= r_phase[r_j] + step_inc;
                r_last_vld[r_j] <= 1'b1;
                r_j             <= i_sts_j_last() ? '0 : r_j + 1'b1;
                r_note          <= (r_note == stde_pkg::NOTE_W'(stde_pkg::NOTES - 1))
                                   ? '0 : r_note + 1'b1;
            end else if (i_ctl.div_store) begin
                r_ref_step[r_j] <= r_div_q;
                r_j             <= i_sts_j_last() ? '0 : r_j + 1'b1;
            end
        end
    end

    // last drawn column
    always_ff @(posedge i_clk) begin
        if (i_ctl.adv) begin
            r_last_col[r_j] <= r_col;
        end
    end

    // divider registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_div_cnt <= '0;
        end else if (i_ctl.div_start || i_ctl.div_store) begin
            r_div_cnt <= '0;
        end else if (i_ctl.div_step) begin
            r_div_cnt <= r_div_cnt + 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_ctl.div_start || i_ctl.div_store) begin
            r_div_num <= r_ref_inc;
            r_div_rem <= '0;
            r_div_q   <= '0;
        end else if (i_ctl.div_step) begin
            r_div_num <= r_div_num << 1;
            r_div_rem <= div_bit ? div_sh - div_dvsr : div_sh;
            r_div_q   <= {r_div_q[stde_pkg::PHASE_W-2:0], div_bit};
        end
    end

    // per-sample pipeline registers
    always_ff @(posedge i_clk) begin
        if (i_ctl.take_sample) begin
            r_s <= i_sample;
        end
        if (i_ctl.rd) begin
            r_col  <= col_cur;
            r_addr <= addr_cur;
        end
        if (i_ctl.mul) begin
            r_prod <= n_prod;
        end
        if (i_ctl.blend) begin
            r_v <= n_v;
        end
        if (i_ctl.pix) begin
            r_y <= n_y;
        end
    end

    // command that enters the holding slot
    assign line_lit = r_bars && (r_v > stde_pkg::EPS_V);
    always_comb begin
        new_cmd.string_index = stde_pkg::IDX_OUT_W'(r_j);
        new_cmd.column       = stde_pkg::COL_OUT_W'(r_col);
        if (i_ctl.push_pix) begin
            new_cmd.kind       = stde_pkg::KIND_PIXEL;
            new_cmd.row_top    = stde_pkg::ROW_OUT_W'(r_y);
            new_cmd.row_bottom = stde_pkg::ROW_OUT_W'(r_y);
            new_cmd.lit        = 1'b1;
        end else begin
            new_cmd.kind       = stde_pkg::KIND_LINE;
            new_cmd.row_top    = stde_pkg::ROW_OUT_W'(y_lo);
            new_cmd.row_bottom = stde_pkg::ROW_OUT_W'(y_hi);
            new_cmd.lit        = line_lit;
        end
    end

    assign push = i_ctl.push_line || i_ctl.push_pix;

    // output register: holds back one command so the final one can be marked
    always_comb begin
        n_out      = r_out;
        n_out_last = r_out_last;
        n_out_vld  = r_out_vld && i_cmd_stall;
        if ((push && r_pend_vld) || i_ctl.flush) begin
            n_out      = r_pend;
            n_out_last = i_ctl.flush;
            n_out_vld  = 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        r_out      <= n_out;
        r_out_last <= n_out_last;
        if (push) begin
            r_pend <= new_cmd;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_vld  <= 1'b0;
            r_pend_vld <= 1'b0;
        end else begin
            r_out_vld <= n_out_vld;
            if (push) begin
                r_pend_vld <= 1'b1;
            end else if (i_ctl.flush) begin
                r_pend_vld <= 1'b0;
            end
        end
    end

    function automatic logic i_sts_j_last();
        return r_j == stde_pkg::J_W'(stde_pkg::STRINGS - 1);
    endfunction

    // status to the sequencer
    assign o_sts.clr_done     = (r_clr_addr == stde_pkg::ADDR_W'(stde_pkg::STORE_DEPTH - 1));
    assign o_sts.div_req      = r_div_req;
    assign o_sts.div_last_bit = (r_div_cnt == stde_pkg::DIV_CNT_W'(stde_pkg::PHASE_W - 1));
    assign o_sts.j_last       = i_sts_j_last();
    assign o_sts.line_need    = !r_last_vld[r_j] || (r_last_col[r_j] != r_col);
    assign o_sts.pix_need     = !r_bars && ((r_v > stde_pkg::EPS_V) || (r_v < stde_pkg::NEG_EPS_V));
    assign o_sts.pend_vld     = r_pend_vld;
    assign o_sts.out_free     = !r_out_vld || !i_cmd_stall;

    // ports
    assign o_cmd       = r_out;
    assign o_cmd_last  = r_out_last;
    assign o_cmd_valid = r_out_vld;

endmodule

// File: rtl/core/strobe_tuner_display_engine.sv
// ----------------------------------------------------------------------------
// strobe_tuner_display_engine
// strobe tuner display: per-string phase strobes turned into draw commands
// ----------------------------------------------------------------------------
// After reset the block clears its 768-entry strobe store, one entry a
// cycle, and takes no sample while it clears (configuration writes are
// taken meanwhile). A write of reference_increment starts a bit-serial divide
// of the step by each string number, one string after the other, with input
// and configuration held off. Each string of a sample then passes through the
// one shared datapath in the order store read, blend multiply, store write
// and pixel row, then pushes its line and pixel commands as needed, which wait
// while the output side stalls; a final step marks and releases the last command.
// Up to 12 commands follow one sample; the last of them carries o_last.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module strobe_tuner_display_engine (
    input  logic                                 i_clk,
    input  logic                                 i_rst_n,
    // sample channel
    input  logic                                 i_sample_valid,
    output logic                                 o_sample_stall,
    input  logic signed [stde_pkg::SAMPLE_W-1:0] i_sample,
    // draw command channel
    output logic                                 o_cmd_valid,
    input  logic                                 i_cmd_stall,
    output logic                                 o_kind,
    output logic [stde_pkg::IDX_OUT_W-1:0]       o_string_index,
    output logic [stde_pkg::COL_OUT_W-1:0]       o_column,
    output logic [stde_pkg::ROW_OUT_W-1:0]       o_row_top,
    output logic [stde_pkg::ROW_OUT_W-1:0]       o_row_bottom,
    output logic                                 o_lit,
    output logic                                 o_last,
    // configuration write channel
    input  logic                                 i_cfg_valid,
    output logic                                 o_cfg_ready,
    input  logic [stde_pkg::CFG_IDX_W-1:0]       i_cfg_index,
    input  logic [stde_pkg::CFG_DATA_W-1:0]      i_cfg_data
);

    stde_pkg::t_ctl      ctl;
    stde_pkg::t_sts      sts;
    stde_pkg::t_draw_cmd cmd;

    // sequencer
    stde_ctrl u_ctrl (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_sample_valid (i_sample_valid),
        .i_cfg_valid    (i_cfg_valid),
        .i_sts          (sts),
        .o_ctl          (ctl)
    );

    // datapath
    stde_dpath u_dpath (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_ctl       (ctl),
        .o_sts       (sts),
        .i_cfg_valid (i_cfg_valid),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data),
        .i_sample    (i_sample),
        .i_cmd_stall (i_cmd_stall),
        .o_cmd       (cmd),
        .o_cmd_last  (o_last),
        .o_cmd_valid (o_cmd_valid)
    );

    // handshake and payload ports
    assign o_sample_stall = ctl.sample_stall;
    assign o_cfg_ready    = ctl.cfg_ready;
    assign o_kind         = cmd.kind;
    assign o_string_index = cmd.string_index;
    assign o_column       = cmd.column;
    assign o_row_top      = cmd.row_top;
    assign o_row_bottom   = cmd.row_bottom;
    assign o_lit          = cmd.lit;

    // sequencing checks
    `STDE_ASSERT_IMPL(a_sample_no_pending, i_clk, i_rst_n, ctl.take_sample, !sts.pend_vld, "sample taken with a command still held")
    `STDE_ASSERT_IMPL(a_push_has_room, i_clk, i_rst_n, (ctl.push_line || ctl.push_pix) && sts.pend_vld, sts.out_free, "held command overwritten")
    `STDE_ASSERT_IMPL(a_flush_has_room, i_clk, i_rst_n, ctl.flush, sts.out_free && sts.pend_vld, "final command released without room")
    `STDE_ASSERT_NEVER(a_cfg_with_sample, i_clk, i_rst_n, ctl.take_sample && i_cfg_valid && ctl.cfg_ready, "config beat and sample beat on one edge")

endmodule
